[src/assert_macros.svh]
// Assertion macros used by the checker file.
// Plain clocked implication forms only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on clk, disabled in reset.
`define ASRT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert a next-cycle implication on clk, disabled in reset.
`define ASRT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[src/lsw_pkg.sv]
// Package for the Lagrange shape weight block: payload types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lsw_pkg;
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] weight;
		logic [3:0]         node_index;
		logic               last;
	} out_item_t;

	// Per-point job handed from front to back: axis weights, degree and 2D flag.
	typedef struct packed {
		logic signed [3:0][31:0] px;
		logic signed [3:0][31:0] py;
		logic [1:0]              deg;
		logic                    two_d;
	} job_t;

	localparam logic [2:0] REG_SPACE_DIM = 3'd0;
	localparam logic [2:0] REG_POLY_DEG  = 3'd1;
	localparam logic [2:0] REG_ORIGIN_X  = 3'd2;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd3;
	localparam logic [2:0] REG_IJ00      = 3'd4;
	localparam logic [2:0] REG_IJ01      = 3'd5;
	localparam logic [2:0] REG_IJ10      = 3'd6;
	localparam logic [2:0] REG_IJ11      = 3'd7;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > S32_MAX) sat32 = 32'sh7fffffff;
		else if (v < S32_MIN) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

[src/lagrange_shape_weights.sv]
// Lagrange shape weights, segment or quadrilateral, degree 1 to 3.
// Produces 2..16 weights per point.
// Throughput: one weight per cycle while out_stall is low. Front pipeline
// takes an item per cycle while queue has room.
// Reset: asynchronous, active low; registers return to identity mapping.
`timescale 1ns / 1ps
`default_nettype none
module lagrange_shape_weights #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int WEIGHT_FRAC_BITS = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  lsw_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  wire                out_stall,
	output lsw_pkg::out_item_t out_item,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [4:0]          paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import lsw_pkg::*;
	localparam int QD = 16;
	logic [1:0] dim_q, deg_q;
	logic signed [31:0] ox_q, oy_q, j00_q, j01_q, j10_q, j11_q;
	logic wr_en;
	logic [2:0] ridx;
	job_t job_f, job_b;
	logic job_fv, job_bv, pop, push;
	logic [$clog2(QD+1)-1:0] cnt;
	logic [3:0] in_pipe;
	logic [3:0] inflight_q;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign ridx = paddr[4:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 2'd1;
			deg_q <= 2'd1;
			ox_q <= '0;
			oy_q <= '0;
			j00_q <= 32'sd1 <<< COORD_FRAC_BITS;
			j01_q <= '0;
			j10_q <= '0;
			j11_q <= 32'sd1 <<< COORD_FRAC_BITS;
		end else if (wr_en) begin
			case (ridx)
				REG_SPACE_DIM: dim_q <= pwdata[1:0];
				REG_POLY_DEG:  deg_q <= pwdata[1:0];
				REG_ORIGIN_X:  ox_q <= pwdata;
				REG_ORIGIN_Y:  oy_q <= pwdata;
				REG_IJ00:      j00_q <= pwdata;
				REG_IJ01:      j01_q <= pwdata;
				REG_IJ10:      j10_q <= pwdata;
				REG_IJ11:      j11_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		case (ridx)
			REG_SPACE_DIM: prdata = {30'd0, dim_q};
			REG_POLY_DEG:  prdata = {30'd0, deg_q};
			REG_ORIGIN_X:  prdata = ox_q;
			REG_ORIGIN_Y:  prdata = oy_q;
			REG_IJ00:      prdata = j00_q;
			REG_IJ01:      prdata = j01_q;
			REG_IJ10:      prdata = j10_q;
			REG_IJ11:      prdata = j11_q;
			default:       prdata = '0;
		endcase
	end

	// Track items in the front pipe so the queue always has room for them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inflight_q <= '0;
		else inflight_q <= inflight_q + ((in_valid & ~in_stall) ? 4'd1 : 4'd0)
			- (job_fv ? 4'd1 : 4'd0);
	end
	assign in_pipe = inflight_q;
	assign in_stall = (5'(cnt) + 5'(in_pipe)) >= 5'(QD - 1);
	assign push = job_fv;

	lsw_front #(.CF(COORD_FRAC_BITS), .WF(WEIGHT_FRAC_BITS)) u_front (
		.clk, .arst_n,
		.in_v(in_valid & ~in_stall), .in_d(in_item), .en(1'b1),
		.space_dim(dim_q), .poly_degree(deg_q),
		.origin_x(ox_q), .origin_y(oy_q),
		.ij00(j00_q), .ij01(j01_q), .ij10(j10_q), .ij11(j11_q),
		.job_v(job_fv), .job(job_f)
	);

	lsw_queue #(.DEPTH(QD)) u_queue (
		.clk, .arst_n, .wr(push), .wdata(job_f), .rd(pop),
		.rdata(job_b), .not_empty(job_bv), .count(cnt)
	);

	lsw_back #(.WF(WEIGHT_FRAC_BITS)) u_back (
		.clk, .arst_n, .job_v(job_bv), .job(job_b), .job_pop(pop),
		.out_valid, .out_item, .out_stall
	);
endmodule
`default_nettype wire

[src/lsw_mulq.sv]
// Fixed-point multiply with round half up and saturation, one register stage.
// Depends on lsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsw_mulq #(
	parameter int F = 24
) (
	input  wire                clk,
	input  wire                en,
	input  wire signed [31:0]  a,
	input  wire signed [31:0]  b,
	output logic signed [31:0] p
);
	import lsw_pkg::*;
	logic signed [63:0] prod;
	logic signed [63:0] rnd;
	assign prod = a * b;
	// Adding half then arithmetic shift is round half toward +inf.
	assign rnd = (prod + (64'sd1 <<< (F - 1))) >>> F;
	always_ff @(posedge clk) begin
		if (en) p <= sat32(rnd);
	end
endmodule
`default_nettype wire

[src/lsw_front.sv]
// Front part: maps a point to local coordinates and evaluates axis polynomials.
// Depends on lsw_pkg and lsw_mulq. Fixed pipeline of eight stages.
`timescale 1ns / 1ps
`default_nettype none
module lsw_front #(
	parameter int CF = 16,
	parameter int WF = 24
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_v,
	input  lsw_pkg::in_item_t in_d,
	input  wire               en,
	input  wire [1:0]         space_dim,
	input  wire [1:0]         poly_degree,
	input  wire signed [31:0] origin_x,
	input  wire signed [31:0] origin_y,
	input  wire signed [31:0] ij00,
	input  wire signed [31:0] ij01,
	input  wire signed [31:0] ij10,
	input  wire signed [31:0] ij11,
	output logic              job_v,
	output lsw_pkg::job_t     job
);
	import lsw_pkg::*;
	localparam int SH = 2 * CF - WF;
	localparam logic signed [63:0] ONE = 64'sd1 <<< WF;
	localparam int NS = 8;

	logic [NS-1:0] v_q;
	logic [1:0] deg_q [NS];
	logic two_d_q [NS];

	// stage 1: differences
	logic signed [32:0] dx_w, dy_w;
	logic signed [31:0] dx_s1, dy_s1;
	assign dx_w = 33'(in_d.point_x) - 33'(origin_x);
	assign dy_w = 33'(in_d.point_y) - 33'(origin_y);
	function automatic logic signed [31:0] clampd(input logic signed [32:0] v);
		if (v > 33'sd2147483647) clampd = 32'sh7fffffff;
		else if (v < -33'sd2147483647) clampd = -32'sh7fffffff;
		else clampd = v[31:0];
	endfunction

	// stage 2: four products
	logic signed [63:0] m00_s2, m01_s2, m10_s2, m11_s2;
	// stage 3: sums rescaled
	logic signed [64:0] sx_w, sy_w;
	logic signed [31:0] x_s3, y_s3;
	function automatic logic signed [31:0] to_local(input logic signed [64:0] s);
		logic signed [64:0] lim;
		logic signed [64:0] t;
		lim = 65'sd1 <<< 40;
		t = s;
		if (SH > 0) begin
			t = (s + (65'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> (SH > 0 ? SH : 0);
		end else if (SH < 0) begin
			if (t > lim) t = lim;
			if (t < -lim) t = -lim;
			t = t <<< (SH < 0 ? -SH : 0);
		end
		if (t > 65'sd2147483647) to_local = 32'sh7fffffff;
		else if (t < -65'sd2147483648) to_local = 32'sh80000000;
		else to_local = t[31:0];
	endfunction

	// stage 4: linear factors per axis (index 0 = x, 1 = y)
	logic signed [31:0] t_s4 [2], a_s4 [2], b_s4 [2], c_s4 [2], e_s4 [2], m_s4 [2];
	logic signed [31:0] t_s5 [2], b_s5 [2], c_s5 [2], e_s5 [2], m_s5 [2];
	logic signed [31:0] t_s6 [2], b_s6 [2], c_s6 [2], e_s6 [2], m_s6 [2];
	logic signed [31:0] c_s7 [2];
	// multiplier outputs
	logic signed [31:0] xc_s5 [2], xe_s5 [2], ec_s5 [2], ab_s5 [2], xb_s5 [2], xa_s5 [2];
	logic signed [31:0] abc_s6 [2], xbc_s6 [2], xac_s6 [2], xab_s6 [2];
	logic signed [31:0] q2_0_s6 [2], q2_1_s6 [2], q2_2_s6 [2];
	logic signed [31:0] q2_0_s7 [2], q2_1_s7 [2], q2_2_s7 [2];
	logic signed [31:0] m_s7 [2], t_s7 [2];
	logic signed [31:0] r_s7 [2][4];
	logic signed [31:0] p_s8 [2][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q[0] <= (poly_degree == 2'd0) ? 2'd1 : poly_degree;
			two_d_q[0] <= (space_dim == 2'd2);
			for (int i = 1; i < NS; i++) begin
				deg_q[i] <= deg_q[i-1];
				two_d_q[i] <= two_d_q[i-1];
			end
			dx_s1 <= clampd(dx_w);
			dy_s1 <= clampd(dy_w);
			m00_s2 <= ij00 * dx_s1;
			m01_s2 <= ij01 * dy_s1;
			m10_s2 <= ij10 * dx_s1;
			m11_s2 <= ij11 * dy_s1;
			x_s3 <= to_local(two_d_q[1] ? 65'(m00_s2) + 65'(m01_s2) : 65'(m00_s2));
			y_s3 <= two_d_q[1] ? to_local(65'(m10_s2) + 65'(m11_s2)) : 32'sd0;
		end
	end
	assign sx_w = '0;
	assign sy_w = '0;

	genvar g;
	generate
		for (g = 0; g < 2; g++) begin : g_axis
			logic signed [31:0] xin;
			logic signed [63:0] xv;
			assign xin = (g == 0) ? x_s3 : y_s3;
			assign xv = 64'(xin);
			always_ff @(posedge clk) begin
				if (en) begin
					t_s4[g] <= xin;
					a_s4[g] <= sat32(3 * xv - ONE);
					b_s4[g] <= sat32(3 * xv - 2 * ONE);
					c_s4[g] <= sat32(xv - ONE);
					e_s4[g] <= sat32(2 * xv - ONE);
					m_s4[g] <= sat32(ONE - xv);
					t_s5[g] <= t_s4[g]; b_s5[g] <= b_s4[g]; c_s5[g] <= c_s4[g];
					e_s5[g] <= e_s4[g]; m_s5[g] <= m_s4[g];
					t_s6[g] <= t_s5[g]; b_s6[g] <= b_s5[g]; c_s6[g] <= c_s5[g];
					e_s6[g] <= e_s5[g]; m_s6[g] <= m_s5[g];
					c_s7[g] <= c_s6[g];
					m_s7[g] <= m_s6[g]; t_s7[g] <= t_s6[g];
					q2_0_s7[g] <= q2_0_s6[g];
					q2_1_s7[g] <= q2_1_s6[g];
					q2_2_s7[g] <= q2_2_s6[g];
				end
			end
			// first products
			lsw_mulq #(.F(WF)) u_xc (.clk, .en, .a(t_s4[g]), .b(c_s4[g]), .p(xc_s5[g]));
			lsw_mulq #(.F(WF)) u_xe (.clk, .en, .a(t_s4[g]), .b(e_s4[g]), .p(xe_s5[g]));
			lsw_mulq #(.F(WF)) u_ec (.clk, .en, .a(e_s4[g]), .b(c_s4[g]), .p(ec_s5[g]));
			lsw_mulq #(.F(WF)) u_ab (.clk, .en, .a(a_s4[g]), .b(b_s4[g]), .p(ab_s5[g]));
			lsw_mulq #(.F(WF)) u_xb (.clk, .en, .a(t_s4[g]), .b(b_s4[g]), .p(xb_s5[g]));
			lsw_mulq #(.F(WF)) u_xa (.clk, .en, .a(t_s4[g]), .b(a_s4[g]), .p(xa_s5[g]));
			// second products
			lsw_mulq #(.F(WF)) u_abc (.clk, .en, .a(ab_s5[g]), .b(c_s5[g]), .p(abc_s6[g]));
			lsw_mulq #(.F(WF)) u_xbc (.clk, .en, .a(xb_s5[g]), .b(c_s5[g]), .p(xbc_s6[g]));
			lsw_mulq #(.F(WF)) u_xac (.clk, .en, .a(xa_s5[g]), .b(c_s5[g]), .p(xac_s6[g]));
			lsw_mulq #(.F(WF)) u_xab (.clk, .en, .a(xa_s5[g]), .b(b_s5[g]), .p(xab_s6[g]));
			always_ff @(posedge clk) begin
				if (en) begin
					q2_0_s6[g] <= ec_s5[g];
					q2_1_s6[g] <= sat32(-64'sd4 * 64'(xc_s5[g]));
					q2_2_s6[g] <= xe_s5[g];
					r_s7[g][0] <= sat32((-64'(abc_s6[g]) + 64'sd1) >>> 1);
					r_s7[g][1] <= sat32((64'sd9 * 64'(xbc_s6[g]) + 64'sd1) >>> 1);
					r_s7[g][2] <= sat32((-64'sd9 * 64'(xac_s6[g]) + 64'sd1) >>> 1);
					r_s7[g][3] <= sat32((64'(xab_s6[g]) + 64'sd1) >>> 1);
					case (deg_q[6])
						2'd2: begin
							p_s8[g][0] <= q2_0_s7[g];
							p_s8[g][1] <= q2_1_s7[g];
							p_s8[g][2] <= q2_2_s7[g];
							p_s8[g][3] <= 32'sd0;
						end
						2'd3: begin
							p_s8[g] <= r_s7[g];
						end
						default: begin
							p_s8[g][0] <= m_s7[g];
							p_s8[g][1] <= t_s7[g];
							p_s8[g][2] <= 32'sd0;
							p_s8[g][3] <= 32'sd0;
						end
					endcase
				end
			end
			for (genvar k = 0; k < 4; k++) begin : g_k
				if (g == 0) begin : g_x
					assign job.px[k] = p_s8[g][k];
				end else begin : g_y
					assign job.py[k] = p_s8[g][k];
				end
			end
		end
	endgenerate

	assign job.deg = deg_q[NS-1];
	assign job.two_d = two_d_q[NS-1];
	assign job_v = v_q[NS-1] & ~(|sx_w) & ~(|sy_w);
endmodule
`default_nettype wire

[src/lsw_queue.sv]
// Short job queue between front and back parts.
// Depends on lsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsw_queue #(
	parameter int DEPTH = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr,
	input  lsw_pkg::job_t  wdata,
	input  wire            rd,
	output lsw_pkg::job_t  rdata,
	output logic           not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import lsw_pkg::*;
	localparam int AW = $clog2(DEPTH);
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			count <= count + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
	assign rdata = mem_q[rp_q];
	assign not_empty = (count != '0);
endmodule
`default_nettype wire

[src/lsw_back.sv]
// Back part: walks nodes of one job, forms 2D products, drives the result port.
// Depends on lsw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsw_back #(
	parameter int WF = 24
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                job_v,
	input  lsw_pkg::job_t      job,
	output logic               job_pop,
	output logic               out_valid,
	output lsw_pkg::out_item_t out_item,
	input  wire                out_stall
);
	import lsw_pkg::*;
	logic [1:0] ix_q, iy_q;
	logic [3:0] k_q;
	logic [1:0] n1;
	logic v_s1;
	logic signed [63:0] prod_s1;
	logic [3:0] k_s1;
	logic last_s1, two_d_s1;
	logic signed [31:0] px_s1;
	logic adv, last_node, ix_end;
	logic signed [63:0] rnd;

	assign n1 = job.deg;
	assign ix_end = (ix_q == n1);
	assign last_node = ix_end & (~job.two_d | (iy_q == n1));
	// stage 1 free when empty or moving into output
	assign adv = ~v_s1 | ~out_valid | ~out_stall;
	assign job_pop = job_v & adv & last_node;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q <= '0;
			iy_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (~out_valid | ~out_stall) out_valid <= v_s1;
			if (adv) begin
				v_s1 <= job_v;
				if (job_v) begin
					if (last_node) begin
						ix_q <= '0;
						iy_q <= '0;
						k_q <= '0;
					end else begin
						ix_q <= ix_end ? 2'd0 : ix_q + 2'd1;
						iy_q <= ix_end ? iy_q + 2'd1 : iy_q;
						k_q <= k_q + 4'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= $signed(job.px[ix_q]) * $signed(job.py[iy_q]);
			px_s1 <= job.px[ix_q];
			k_s1 <= k_q;
			last_s1 <= last_node;
			two_d_s1 <= job.two_d;
		end
		if (~out_valid | ~out_stall) begin
			out_item.weight <= two_d_s1 ? sat32(rnd) : px_s1;
			out_item.node_index <= k_s1;
			out_item.last <= last_s1;
		end
	end
	assign rnd = (prod_s1 + (64'sd1 <<< (WF - 1))) >>> WF;
endmodule
`default_nettype wire

[src/lsw_checker.sv]
// Port-level checker for lagrange_shape_weights, bound to the top level.
// Depends on lsw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lsw_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_stall,
	input lsw_pkg::out_item_t out_item,
	input wire                pready
);
	import lsw_pkg::*;
	`ASRT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`ASRT_IMPL(a_first, clk, arst_n, out_valid && $past(out_valid && !out_stall && out_item.last), out_item.node_index == 4'd0)
	`ASRT_IMPL(a_seq, clk, arst_n, out_valid && $past(out_valid && !out_stall && !out_item.last), out_item.node_index == $past(out_item.node_index) + 4'd1)
	`ASRT_IMPL(a_rdy, clk, arst_n, 1'b1, pready)
endmodule
bind lagrange_shape_weights lsw_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_item, .pready
);
`default_nettype wire
